FILE: rtl/core/pgw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pgw_pkg;

	// Item function codes on the request channel.
	typedef enum logic [1:0] {
		FUNC_XLATE  = 2'd0,
		FUNC_SET_WR = 2'd1,
		FUNC_CLR_G  = 2'd2,
		FUNC_RESP   = 2'd3
	} func_t;

	// Result kinds on the response channel.
	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_WR,
		ST_RD,
		ST_DONE
	} state_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DMAP_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROOT = 2'd1;

	// Field widths.
	localparam int VA_W    = 48;
	localparam int PA_W    = 52;
	localparam int ROOT_W  = 32;
	localparam int ENTRY_W = 64;
	localparam int IDX_W   = 9;

	// Table entry bit positions.
	localparam int BIT_P  = 0;
	localparam int BIT_RW = 1;
	localparam int BIT_PS = 7;
	localparam int BIT_G  = 8;
	localparam int BIT_XO = 58;

	localparam logic [ENTRY_W-1:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;

	// Result of evaluating one table entry.
	typedef struct packed {
		logic                leaf;
		logic                need_wr;
		logic [ENTRY_W-1:0]  new_entry;
		logic [PA_W-1:0]     pa;
	} eval_t;

endpackage

`default_nettype wire

FILE: rtl/core/pgw_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pgw_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [47:0] virt_addr;
	logic [31:0] root_table;
	logic [63:0] read_data;

	modport source (output valid, func, virt_addr, root_table, read_data, input ready);
	modport sink (input valid, func, virt_addr, root_table, read_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pgw_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pgw_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [63:0] mem_addr;
	logic [63:0] write_data;
	logic [51:0] phys_addr;
	logic        fault;
	logic        last;

	modport source (output valid, kind, mem_addr, write_data, phys_addr, fault, last,
		input ready);
	modport sink (input valid, kind, mem_addr, write_data, phys_addr, fault, last,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pgw_addr_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared entry address adder: direct-map base plus table frame plus index times 8.
module pgw_addr_unit #(
	parameter int LEVELS = 4
) (
	input  wire logic [63:0]                 dmap_base,
	input  wire logic [51:0]                 table_addr,
	input  wire logic [47:0]                 vaddr,
	input  wire logic [$clog2(LEVELS)-1:0]   level,
	output      logic [63:0]                 entry_addr
);
	import pgw_pkg::*;

	localparam int TOP_SHIFT = 12 + 9 * (LEVELS - 1);

	logic [5:0]       shift;
	logic [IDX_W-1:0] idx;

	// Select the nine index bits of the virtual address for this level.
	always_comb begin
		shift = 6'(TOP_SHIFT - 9 * int'(level));
		idx   = IDX_W'(vaddr >> shift);
	end

	// One wide three-input add, wrapping modulo 2^64.
	assign entry_addr = dmap_base + {12'd0, table_addr[51:12], 12'd0}
		+ {52'd0, idx, 3'd0};

endmodule

`default_nettype wire

FILE: rtl/core/pgw_entry_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes one returned table entry: leaf test, modified entry and translation.
module pgw_entry_eval #(
	parameter int LEVELS = 4
) (
	input  wire logic [63:0]               entry,
	input  wire logic [1:0]                mode,
	input  wire logic [$clog2(LEVELS)-1:0] level,
	input  wire logic [47:0]               vaddr,
	output      pgw_pkg::eval_t            res
);
	import pgw_pkg::*;

	localparam int TOP_SHIFT = 12 + 9 * (LEVELS - 1);

	logic [5:0]  shift;
	logic [63:0] ofs;
	logic [63:0] ne;
	logic [63:0] pa_full;
	logic        leaf;

	always_comb begin
		// Large pages end the walk only at the 1 GiB and 2 MiB levels.
		leaf = ((int'(level) + 1) >= LEVELS) ||
			(((int'(level) + 3) >= LEVELS) && (level != '0) && entry[BIT_PS]);

		shift = 6'(TOP_SHIFT - 9 * int'(level));
		ofs   = (64'd1 << shift) - 64'd1;

		// Set-writable rewrites every level; clear-global touches the leaf only.
		ne = entry;
		if (mode == FUNC_SET_WR) begin
			ne = entry;
			ne[BIT_RW] = 1'b1;
			ne[BIT_XO] = 1'b0;
		end else if (mode == FUNC_CLR_G && leaf) begin
			ne[BIT_G] = 1'b0;
		end

		pa_full = ((ne & FRAME_MASK) & ~ofs) | ({16'd0, vaddr} & ofs);

		res.leaf      = leaf;
		res.new_entry = ne;
		res.need_wr   = (mode == FUNC_SET_WR) ? (ne != entry) :
			((mode == FUNC_CLR_G) && leaf);
		res.pa        = (mode == FUNC_SET_WR) ? '0 : pa_full[PA_W-1:0];
	end

endmodule

`default_nettype wire

FILE: rtl/core/four_level_page_table_walker.sv
// Sequence: a start item goes through the address state to its read request; a
// response item gives its write (if any) first, then the next read through the
// address state, or the finish.
// One item at a time: a new item is taken only when idle, once every result of the
// item before it has been taken; an ignored response leaves the block idle.
// Reset (arst_n low) clears the sequencer, the walk state and both config registers.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker #(
	parameter int LEVELS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pgw_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [63:0]                   cfg_data,
	pgw_req_if.sink                            req,
	pgw_rsp_if.source                          rsp
);
	import pgw_pkg::*;

	localparam int LW = $clog2(LEVELS);

	state_t          state_q, state_d;
	logic [63:0]     dmap_q;
	logic [51:0]     kroot_q;
	logic            busy_q;
	logic [1:0]      mode_q;
	logic [LW-1:0]   level_q;
	logic [47:0]     vaddr_q;
	logic [51:0]     table_q;
	logic [63:0]     pending_q;
	logic [63:0]     wdata_q;
	logic [51:0]     pa_q;
	logic            fault_q;
	logic            leaf_q;

	logic            req_fire;
	logic            rsp_fire;
	logic            is_start;
	logic [63:0]     entry_addr;
	eval_t           ev;

	assign req_fire = req.valid && req.ready;
	assign rsp_fire = rsp.valid && rsp.ready;
	assign is_start = (req.func != FUNC_RESP);

	pgw_addr_unit #(.LEVELS(LEVELS)) u_addr (
		.dmap_base  (dmap_q),
		.table_addr (table_q),
		.vaddr      (vaddr_q),
		.level      (level_q),
		.entry_addr (entry_addr)
	);

	pgw_entry_eval #(.LEVELS(LEVELS)) u_eval (
		.entry (req.read_data),
		.mode  (mode_q),
		.level (level_q),
		.vaddr (vaddr_q),
		.res   (ev)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmap_q  <= '0;
			kroot_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_DMAP_BASE) begin
				dmap_q <= cfg_data;
			end else if (cfg_idx == CFG_KERNEL_ROOT) begin
				kroot_q <= cfg_data[51:0];
			end
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs; ready is always high when idle.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (is_start) begin
						state_d = ST_CALC;
					end else if (busy_q) begin
						if (!req.read_data[BIT_P]) begin
							state_d = ST_DONE;
						end else if (ev.need_wr) begin
							state_d = ST_WR;
						end else if (ev.leaf) begin
							state_d = ST_DONE;
						end else begin
							state_d = ST_CALC;
						end
					end
				end
			end
			ST_CALC: state_d = ST_RD;
			ST_WR: begin
				if (rsp_fire) begin
					state_d = leaf_q ? ST_DONE : ST_CALC;
				end
			end
			ST_RD, ST_DONE: begin
				if (rsp_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			mode_q  <= '0;
			level_q <= '0;
			vaddr_q <= '0;
			fault_q <= 1'b0;
			leaf_q  <= 1'b0;
		end else if (state_q == ST_IDLE && req_fire) begin
			if (is_start) begin
				busy_q  <= 1'b1;
				mode_q  <= req.func;
				level_q <= '0;
				vaddr_q <= req.virt_addr;
			end else if (busy_q) begin
				if (!req.read_data[BIT_P]) begin
					busy_q  <= 1'b0;
					fault_q <= 1'b1;
				end else begin
					fault_q <= 1'b0;
					leaf_q  <= ev.leaf;
					if (ev.leaf) begin
						busy_q <= 1'b0;
					end else begin
						level_q <= level_q + LW'(1);
					end
				end
			end
		end
	end

	// Payload registers: table pointer, entry address, write data, translation.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_fire) begin
			if (is_start) begin
				table_q <= (req.func == FUNC_XLATE) ? {20'd0, req.root_table} : kroot_q;
			end else if (busy_q) begin
				table_q <= ev.new_entry[51:0];
				wdata_q <= ev.new_entry;
				pa_q    <= req.read_data[BIT_P] ? ev.pa : '0;
			end
		end
		if (state_q == ST_CALC) begin
			pending_q <= entry_addr;
		end
	end

	// Result payload follows the presenting state.
	always_comb begin
		rsp.valid      = 1'b0;
		rsp.kind       = KIND_READ;
		rsp.mem_addr   = '0;
		rsp.write_data = '0;
		rsp.phys_addr  = '0;
		rsp.fault      = 1'b0;
		rsp.last       = 1'b0;
		case (state_q)
			ST_WR: begin
				rsp.valid      = 1'b1;
				rsp.kind       = KIND_WRITE;
				rsp.mem_addr   = pending_q;
				rsp.write_data = wdata_q;
			end
			ST_RD: begin
				rsp.valid    = 1'b1;
				rsp.kind     = KIND_READ;
				rsp.mem_addr = pending_q;
				rsp.last     = 1'b1;
			end
			ST_DONE: begin
				rsp.valid     = 1'b1;
				rsp.kind      = KIND_DONE;
				rsp.phys_addr = pa_q;
				rsp.fault     = fault_q;
				rsp.last      = 1'b1;
			end
			default: rsp.valid = 1'b0;
		endcase
	end

`ifndef SYNTH
	// Inputs are never taken while a result is still on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request taken while a result is pending");

	// The address cycle always leads to the read request.
	a_calc_to_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC |=> state_q == ST_RD)
		else $error("address cycle not followed by read");

	// A taken write is followed by the next address or the finish.
	a_wr_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR && rsp.ready) |=> (state_q == ST_CALC || state_q == ST_DONE))
		else $error("write not followed by address or finish");

	// The level stays within the table depth during a walk.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (int'(level_q) < LEVELS))
		else $error("walk level out of range");
`endif

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import pgw_pkg::*;

	localparam int          LEVELS        = 4;
	localparam int          N_PHASES      = 6;
	localparam int          PHASE_ITEMS   = 170;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          MAX_PRINTS    = 40;
	localparam logic [63:0] IDX_MASK      = 64'h1FF;

	// How a row of the directed table is checked.
	typedef enum logic [1:0] {
		CHK_MODEL,
		CHK_ONE,
		CHK_NONE
	} row_chk_t;

	typedef struct packed {
		func_t        func;
		logic [47:0]  va;
		logic [31:0]  root;
		logic [63:0]  rd;
	} req_item_t;

	typedef struct packed {
		kind_t        kind;
		logic [63:0]  addr;
		logic [63:0]  wdata;
		logic [51:0]  pa;
		logic         fault;
		logic         last;
	} rsp_item_t;

	typedef struct packed {
		req_item_t    item;
		row_chk_t     chk;
		rsp_item_t    want;
	} dir_row_t;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [63:0] cfg_data;

	pgw_req_if req_ch ();
	pgw_rsp_if rsp_ch ();

	four_level_page_table_walker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor copy of the registers and the walk in progress.
	logic [63:0] dmap_base_q;
	logic [51:0] kroot_q;
	bit          walking;
	func_t       walk_md;
	int unsigned walk_lvl;
	logic [47:0] walk_va;
	logic [63:0] entry_addr_q;

	// Results of the latest item, and all results still owed by the block.
	rsp_item_t   step_out [2];
	int          step_n;
	rsp_item_t   walk_results_due [$];
	dir_row_t    plan [$];

	int unsigned n_errors, n_items, n_ignored, n_checked, n_writes, n_done, n_faults;
	int unsigned n_holds, n_settings;
	bit          req_steady, rsp_steady, hold_req;

	task automatic report_mismatch(string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
	endtask

	function automatic int unsigned lvl_shift(int unsigned lvl);
		return 12 + 9 * (LEVELS - 1) - 9 * lvl;
	endfunction

	function automatic logic [63:0] pte_addr(logic [63:0] tbl_pa, int unsigned lvl);
		logic [63:0] idx;
		idx = ({16'd0, walk_va} >> lvl_shift(lvl)) & IDX_MASK;
		return dmap_base_q + (tbl_pa & FRAME_MASK) + (idx << 3);
	endfunction

	function automatic void emit_result(kind_t k, logic [63:0] addr, logic [63:0] wdata,
		logic [63:0] pa, logic fault, logic last);
		step_out[step_n] = '{kind: k, addr: addr, wdata: wdata, pa: pa[51:0],
			fault: fault, last: last};
		step_n++;
	endfunction

	// Work out the results that one accepted item causes, updating the walk.
	function automatic void advance_walk(req_item_t it);
		logic [63:0] root, e, ne, ofs, pa;
		bit          leaf;
		step_n = 0;
		if (it.func != FUNC_RESP) begin
			root = (it.func == FUNC_XLATE) ? {32'd0, it.root} : {12'd0, kroot_q};
			walking = 1'b1;
			walk_md = it.func;
			walk_lvl = 0;
			walk_va = it.va;
			entry_addr_q = pte_addr(root, 0);
			emit_result(KIND_READ, entry_addr_q, '0, '0, 1'b0, 1'b1);
			return;
		end
		if (!walking)
			return;
		e = it.rd;

		// A non-present entry ends the walk with a fault and no write.
		if (!e[BIT_P]) begin
			walking = 1'b0;
			emit_result(KIND_DONE, '0, '0, '0, 1'b1, 1'b1);
			return;
		end

		leaf = (walk_lvl + 1 >= LEVELS) ||
			(walk_lvl + 3 >= LEVELS && walk_lvl > 0 && e[BIT_PS]);

		// Entry rewrites: set-writable at every level, clear-global on the leaf.
		if (walk_md == FUNC_SET_WR) begin
			ne = e;
			ne[BIT_RW] = 1'b1;
			ne[BIT_XO] = 1'b0;
			if (ne != e)
				emit_result(KIND_WRITE, entry_addr_q, ne, '0, 1'b0, 1'b0);
			e = ne;
		end else if (walk_md == FUNC_CLR_G && leaf) begin
			e[BIT_G] = 1'b0;
			emit_result(KIND_WRITE, entry_addr_q, e, '0, 1'b0, 1'b0);
		end

		if (leaf) begin
			ofs = (64'd1 << lvl_shift(walk_lvl)) - 64'd1;
			pa = '0;
			if (walk_md != FUNC_SET_WR)
				pa = ((e & FRAME_MASK) & ~ofs) | ({16'd0, walk_va} & ofs);
			walking = 1'b0;
			emit_result(KIND_DONE, '0, '0, pa, 1'b0, 1'b1);
		end else begin
			walk_lvl++;
			entry_addr_q = pte_addr(e, walk_lvl);
			emit_result(KIND_READ, entry_addr_q, '0, '0, 1'b0, 1'b1);
		end
	endfunction

	function automatic int unsigned pick_gap(bit steady);
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random entry: mostly present, large-page bit now and then.
	function automatic logic [63:0] make_entry();
		logic [63:0] e;
		e = {$urandom, $urandom};
		e[BIT_P] = ($urandom_range(0, 15) != 0);
		e[BIT_PS] = ($urandom_range(0, 3) == 0);
		return e;
	endfunction

	function automatic req_item_t make_item(func_t f);
		req_item_t   it;
		logic [63:0] w;
		w = {$urandom, $urandom};
		it.func = f;
		it.va = w[47:0];
		it.root = $urandom;
		it.rd = make_entry();
		return it;
	endfunction

	function automatic void add_row(func_t f, logic [47:0] va, logic [31:0] rt,
		logic [63:0] rd, row_chk_t chk, kind_t k, logic [63:0] addr, logic fault);
		dir_row_t row;
		row.item = '{func: f, va: va, root: rt, rd: rd};
		row.chk = chk;
		row.want = '{kind: k, addr: addr, wdata: '0, pa: '0, fault: fault, last: 1'b1};
		plan.push_back(row);
	endfunction

	task automatic pause_req(int unsigned cycles);
		if (cycles == 0)
			return;
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Offer one item, wait for it to be taken, and record what it should cause.
	task automatic issue(req_item_t it, row_chk_t chk, rsp_item_t want);
		req_ch.valid      <= 1'b1;
		req_ch.func       <= it.func;
		req_ch.virt_addr  <= it.va;
		req_ch.root_table <= it.root;
		req_ch.read_data  <= it.rd;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		advance_walk(it);
		case (chk)
			CHK_MODEL: begin
				for (int k = 0; k < step_n; k++)
					walk_results_due.push_back(step_out[k]);
			end
			CHK_ONE: walk_results_due.push_back(want);
			default: ;
		endcase
		if (step_n == 0)
			n_ignored++;
		else
			n_items++;
		pause_req(pick_gap(req_steady));
	endtask

	// Stop offering, wait for every owed result, then let the block settle.
	task automatic quiesce();
		req_ch.valid <= 1'b0;
		while (walk_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_registers(logic [63:0] dmap, logic [63:0] kroot);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_DMAP_BASE;
		cfg_data <= dmap;
		@(posedge clk);
		cfg_idx  <= CFG_KERNEL_ROOT;
		cfg_data <= kroot;
		@(posedge clk);
		cfg_we <= 1'b0;
		dmap_base_q = dmap;
		kroot_q = kroot[51:0];
		n_settings++;
	endtask

	// A start item followed by responses until the walk ends or is abandoned.
	task automatic walk_once(func_t md);
		issue(make_item(md), CHK_MODEL, '0);
		while (walking) begin
			if ($urandom_range(0, 15) == 0)
				return;
			issue(make_item(FUNC_RESP), CHK_MODEL, '0);
		end
	endtask

	// Result side: accept with random stalls, and one long hold-off on request.
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				n_holds++;
				stall_left = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else if (rsp_steady || $urandom_range(0, 3) != 0) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				stall_left = pick_gap(1'b0);
				rsp_ch.ready <= 1'b0;
			end
		end
	end

	// Compare every accepted result with the oldest one owed.
	always @(posedge clk) begin : result_check
		rsp_item_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (walk_results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result, kind %0d addr %h",
					rsp_ch.kind, rsp_ch.mem_addr));
			end else begin
				want = walk_results_due.pop_front();
				n_checked++;
				if (want.kind == KIND_WRITE)
					n_writes++;
				if (want.kind == KIND_DONE)
					n_done++;
				if (want.fault)
					n_faults++;
				check_field("kind", 64'(rsp_ch.kind), 64'(want.kind));
				check_field("mem_addr", rsp_ch.mem_addr, want.addr);
				check_field("write_data", rsp_ch.write_data, want.wdata);
				check_field("phys_addr", 64'(rsp_ch.phys_addr), 64'(want.pa));
				check_field("fault", 64'(rsp_ch.fault), 64'(want.fault));
				check_field("last", 64'(rsp_ch.last), 64'(want.last));
			end
		end
	end

	initial begin : stimulus
		int unsigned goal;
		int unsigned r;
		bit          paused;

		req_ch.valid      <= 1'b0;
		req_ch.func       <= FUNC_XLATE;
		req_ch.virt_addr  <= '0;
		req_ch.root_table <= '0;
		req_ch.read_data  <= '0;
		cfg_we   <= 1'b0;
		cfg_idx  <= CFG_DMAP_BASE;
		cfg_data <= '0;
		dmap_base_q = '0;
		kroot_q = '0;
		walking = 1'b0;
		walk_md = FUNC_XLATE;
		walk_lvl = 0;
		walk_va = '0;
		entry_addr_q = '0;
		paused = 1'b0;

		// Directed table; registers still hold their reset values of zero.
		add_row(FUNC_XLATE, '0, '0, '0, CHK_ONE, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h0, CHK_ONE, KIND_DONE, 64'h0, 1'b1);
		add_row(FUNC_RESP, '1, '1, '1, CHK_NONE, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_XLATE, '1, '1, '0, CHK_ONE, KIND_READ, 64'hFFFF_FFF8, 1'b0);
		add_row(FUNC_RESP, '0, '0, '1, CHK_MODEL, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, '1, CHK_MODEL, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_XLATE, 48'h1234_5678_9ABC, 32'h0000_1000, '0, CHK_MODEL, KIND_READ,
			64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h2001, CHK_MODEL, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h3001, CHK_MODEL, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h4001, CHK_MODEL, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h8000_0000_0005_6081, CHK_MODEL, KIND_READ,
			64'h0, 1'b0);
		add_row(FUNC_SET_WR, '0, '0, '0, CHK_ONE, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h1, CHK_MODEL, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h3003, CHK_MODEL, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h0400_0000_0020_0083, CHK_MODEL, KIND_READ,
			64'h0, 1'b0);
		add_row(FUNC_CLR_G, '1, '1, '0, CHK_ONE, KIND_READ, 64'hFF8, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h101, CHK_MODEL, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h1001, CHK_MODEL, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h000F_FFFF_FFFF_F081, CHK_MODEL, KIND_READ,
			64'h0, 1'b0);
		add_row(FUNC_XLATE, '0, 32'h0000_5000, '0, CHK_MODEL, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_SET_WR, '0, '0, '0, CHK_ONE, KIND_READ, 64'h0, 1'b0);
		add_row(FUNC_RESP, '0, '0, 64'h0, CHK_ONE, KIND_DONE, 64'h0, 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			issue(plan[i].item, plan[i].chk, plan[i].want);

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			// End any open walk with a non-present entry so the block is idle.
			if (walking)
				issue('{func: FUNC_RESP, va: '0, root: '0, rd: '0}, CHK_MODEL, '0);
			quiesce();
			case (ph)
				0: set_registers(64'h0, '1);
				1: set_registers('1, 64'h0);
				3: set_registers(64'hFFFF_8880_0000_0000, {$urandom, $urandom});
				default: set_registers({$urandom, $urandom}, {$urandom, $urandom});
			endcase
			req_steady = (ph == 2) || (ph == 5);
			rsp_steady = (ph == 5);
			if (ph == 2)
				hold_req = 1'b1;
			goal = n_items + PHASE_ITEMS;
			while (n_items < goal) begin
				// Once, let every owed result come back before going on.
				if (ph == 4 && !paused && n_items + PHASE_ITEMS / 2 >= goal) begin
					quiesce();
					paused = 1'b1;
				end
				r = $urandom_range(0, 99);
				if (r < 78)
					walk_once(func_t'($urandom_range(0, 2)));
				else if (r < 86)
					issue(make_item(FUNC_RESP), CHK_MODEL, '0);
				else
					issue(make_item(func_t'($urandom_range(0, 3))), CHK_MODEL, '0);
			end
		end

		quiesce();
		$display("Ran %0d items, %0d ignored responses, %0d settings, %0d long stalls.",
			n_items, n_ignored, n_settings, n_holds);
		$display("Checked %0d results: %0d entry writes, %0d finished walks, %0d faults.",
			n_checked, n_writes, n_done, n_faults);
		if (n_errors == 0 && walk_results_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Hard limit, well past the slowest legal run.
	initial begin : watchdog
		#6_000_000;
		$display("Timed out with %0d results still owed.", walk_results_due.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
